>>> rtl/lms_pkg.sv
package lms_pkg;

  localparam int LEVEL_W = 13;
  localparam int STEP_W  = 8;
  localparam int DWELL_W = 10;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 3;

  typedef enum logic [1:0] {
    MODE_CHASE_UP,
    MODE_BLINK,
    MODE_CHASE_DOWN,
    MODE_BREATHE
  } mode_t;

  localparam logic [1:0] EVT_B1   = 2'd0;
  localparam logic [1:0] EVT_B2   = 2'd1;
  localparam logic [1:0] EVT_B3   = 2'd2;
  localparam logic [1:0] EVT_NONE = 2'd3;

  localparam logic [REG_W-1:0] REG_PWM_TOP          = 3'd0;
  localparam logic [REG_W-1:0] REG_RAMP_STEP        = 3'd1;
  localparam logic [REG_W-1:0] REG_DWELL_CHASE_UP   = 3'd2;
  localparam logic [REG_W-1:0] REG_DWELL_BLINK      = 3'd3;
  localparam logic [REG_W-1:0] REG_DWELL_CHASE_DOWN = 3'd4;
  localparam logic [REG_W-1:0] REG_DWELL_BREATHE    = 3'd5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 13'd8191;

  localparam logic [LEVEL_W-1:0] RST_PWM_TOP          = 13'd5000;
  localparam logic [STEP_W-1:0]  RST_RAMP_STEP        = 8'd50;
  localparam logic [DWELL_W-1:0] RST_DWELL_CHASE_UP   = 10'd300;
  localparam logic [DWELL_W-1:0] RST_DWELL_BLINK      = 10'd300;
  localparam logic [DWELL_W-1:0] RST_DWELL_CHASE_DOWN = 10'd200;
  localparam logic [DWELL_W-1:0] RST_DWELL_BREATHE    = 10'd10;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_top;
    logic [STEP_W-1:0]  ramp_step;
    logic [DWELL_W-1:0] dwell_chase_up;
    logic [DWELL_W-1:0] dwell_blink;
    logic [DWELL_W-1:0] dwell_chase_down;
    logic [DWELL_W-1:0] dwell_breathe;
  } cfg_t;

  typedef struct packed {
    logic               pwm_enable;
    logic [LEVEL_W-1:0] pwm_level;
    mode_t              mode;
    logic [DWELL_W-1:0] dwell_ms;
  } stat_t;

  function automatic mode_t next_mode(mode_t cur, logic [1:0] evt);
    mode_t m;
    m = cur;
    unique case (cur)
      MODE_CHASE_UP: begin
        unique case (evt)
          EVT_B1:   m = MODE_CHASE_DOWN;
          EVT_B2:   m = MODE_BLINK;
          EVT_B3:   m = MODE_BREATHE;
          EVT_NONE: m = MODE_CHASE_UP;
        endcase
      end
      MODE_BLINK: begin
        unique case (evt)
          EVT_B1:   m = MODE_CHASE_UP;
          EVT_B2:   m = MODE_CHASE_DOWN;
          EVT_B3:   m = MODE_BREATHE;
          EVT_NONE: m = MODE_BLINK;
        endcase
      end
      MODE_CHASE_DOWN: begin
        unique case (evt)
          EVT_B1:   m = MODE_BLINK;
          EVT_B2:   m = MODE_CHASE_UP;
          EVT_B3:   m = MODE_BREATHE;
          EVT_NONE: m = MODE_CHASE_DOWN;
        endcase
      end
      MODE_BREATHE: begin
        m = (evt == EVT_NONE) ? MODE_BREATHE : MODE_CHASE_UP;
      end
    endcase
    return m;
  endfunction

endpackage

>>> rtl/lms_regs.sv
module lms_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lms_pkg::ADDR_W-1:0] paddr,
  input  logic [lms_pkg::DATA_W-1:0] pwdata,
  output logic [lms_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lms_pkg::cfg_t              cfg
);
  import lms_pkg::*;

  cfg_t             cfg_r;
  logic [REG_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_top          <= RST_PWM_TOP;
      cfg_r.ramp_step        <= RST_RAMP_STEP;
      cfg_r.dwell_chase_up   <= RST_DWELL_CHASE_UP;
      cfg_r.dwell_blink      <= RST_DWELL_BLINK;
      cfg_r.dwell_chase_down <= RST_DWELL_CHASE_DOWN;
      cfg_r.dwell_breathe    <= RST_DWELL_BREATHE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PWM_TOP:          cfg_r.pwm_top          <= pwdata[LEVEL_W-1:0];
        REG_RAMP_STEP:        cfg_r.ramp_step        <= pwdata[STEP_W-1:0];
        REG_DWELL_CHASE_UP:   cfg_r.dwell_chase_up   <= pwdata[DWELL_W-1:0];
        REG_DWELL_BLINK:      cfg_r.dwell_blink      <= pwdata[DWELL_W-1:0];
        REG_DWELL_CHASE_DOWN: cfg_r.dwell_chase_down <= pwdata[DWELL_W-1:0];
        REG_DWELL_BREATHE:    cfg_r.dwell_breathe    <= pwdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PWM_TOP:          prdata = DATA_W'(cfg_r.pwm_top);
      REG_RAMP_STEP:        prdata = DATA_W'(cfg_r.ramp_step);
      REG_DWELL_CHASE_UP:   prdata = DATA_W'(cfg_r.dwell_chase_up);
      REG_DWELL_BLINK:      prdata = DATA_W'(cfg_r.dwell_blink);
      REG_DWELL_CHASE_DOWN: prdata = DATA_W'(cfg_r.dwell_chase_down);
      REG_DWELL_BREATHE:    prdata = DATA_W'(cfg_r.dwell_breathe);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> rtl/lms_engine.sv
module lms_engine #(
  parameter int LED_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [1:0]           evt,
  input  lms_pkg::cfg_t        cfg,
  output logic [LED_COUNT-1:0] pins_nxt,
  output lms_pkg::stat_t       stat_nxt
);
  import lms_pkg::*;

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

  mode_t              mode_r, mode_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt, other;
  logic [LED_COUNT-1:0] pins_r, pins_w;
  logic [LEVEL_W-1:0] ramp_r, ramp_nxt;
  logic               up_r, up_nxt;
  logic               pwm_on_r, pwm_on_nxt;
  logic [LEVEL_W-1:0] applied_r, applied_nxt;
  logic [LEVEL_W:0]   ramp_sum;
  logic [LEVEL_W-1:0] step_ext;

  assign step_ext = LEVEL_W'(cfg.ramp_step);
  assign ramp_sum = {1'b0, ramp_r} + {1'b0, step_ext};

  always_comb begin
    mode_nxt    = next_mode(mode_r, evt);
    idx_nxt     = idx_r;
    pins_w      = pins_r;
    ramp_nxt    = ramp_r;
    up_nxt      = up_r;
    pwm_on_nxt  = pwm_on_r;
    applied_nxt = applied_r;
    other       = '0;

    // mode change: leave the old mode, enter the new one
    if (mode_nxt != mode_r) begin
      if (mode_r == MODE_BREATHE) begin
        applied_nxt = '0;
        pwm_on_nxt  = 1'b0;
      end
      pins_w  = '0;
      idx_nxt = (mode_nxt == MODE_CHASE_DOWN) ? IDX_LAST : '0;
      if (mode_nxt == MODE_BREATHE) begin
        pwm_on_nxt = 1'b1;
        up_nxt     = 1'b1;
      end
    end

    unique case (mode_nxt)
      MODE_CHASE_UP: begin
        other = (idx_nxt != '0) ? idx_nxt - 1'b1 : IDX_LAST;
        pins_w[other]   = 1'b0;
        pins_w[idx_nxt] = 1'b1;
        idx_nxt = (idx_nxt == IDX_LAST) ? '0 : idx_nxt + 1'b1;
      end
      MODE_BLINK: begin
        pins_w = (|pins_w) ? '0 : '1;
      end
      MODE_CHASE_DOWN: begin
        other = (idx_nxt != IDX_LAST) ? idx_nxt + 1'b1 : '0;
        pins_w[other]   = 1'b0;
        pins_w[idx_nxt] = 1'b1;
        idx_nxt = (idx_nxt == '0) ? IDX_LAST : idx_nxt - 1'b1;
      end
      MODE_BREATHE: begin
        applied_nxt = ramp_r;
        if (up_nxt) begin
          ramp_nxt = ramp_sum[LEVEL_W] ? LEVEL_MAX : ramp_sum[LEVEL_W-1:0];
          if (ramp_nxt >= cfg.pwm_top) up_nxt = 1'b0;
        end else begin
          ramp_nxt = (ramp_r > step_ext) ? ramp_r - step_ext : '0;
          if (ramp_nxt == '0) up_nxt = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    pins_nxt            = pins_w;
    stat_nxt.pwm_enable = pwm_on_nxt;
    stat_nxt.pwm_level  = applied_nxt;
    stat_nxt.mode       = mode_nxt;
    unique case (mode_nxt)
      MODE_CHASE_UP:   stat_nxt.dwell_ms = cfg.dwell_chase_up;
      MODE_BLINK:      stat_nxt.dwell_ms = cfg.dwell_blink;
      MODE_CHASE_DOWN: stat_nxt.dwell_ms = cfg.dwell_chase_down;
      MODE_BREATHE:    stat_nxt.dwell_ms = cfg.dwell_breathe;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CHASE_UP;
      idx_r     <= '0;
      pins_r    <= '0;
      ramp_r    <= '0;
      up_r      <= 1'b0;
      pwm_on_r  <= 1'b0;
      applied_r <= '0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      idx_r     <= idx_nxt;
      pins_r    <= pins_w;
      ramp_r    <= ramp_nxt;
      up_r      <= up_nxt;
      pwm_on_r  <= pwm_on_nxt;
      applied_r <= applied_nxt;
    end
  end

endmodule

>>> rtl/led_mode_sequencer.sv
// Four-mode LED sequencer. Each input beat ends one dwell period and carries the
// button event seen (0 b1, 1 b2, 2 b3, 3 none); each one yields exactly one result
// beat with the LED pins, PWM enable and level, the current mode and the dwell of
// the coming period. A beat is taken into an input register; the mode and LED state
// update as the result register loads, which a stall on the result side can delay,
// and one beat per cycle is sustained while the result side does not stall, set by
// the single state-update step between the two registers. A stall on the result
// side holds the input register and reaches in_stall in the same cycle.
// Registers sit on the APB-style port at byte addresses 0x00 pwm_top, 0x04
// ramp_step, 0x08 to 0x14 the dwells of chase up, blink, chase down and breathe;
// write them only while no beat is in flight.
module led_mode_sequencer #(
  parameter int LED_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_button_event,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [LED_COUNT-1:0]           out_led_pins,
  output logic                           out_pwm_enable,
  output logic [lms_pkg::LEVEL_W-1:0]    out_pwm_level,
  output logic [1:0]                     out_mode,
  output logic [lms_pkg::DWELL_W-1:0]    out_dwell_ms,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lms_pkg::ADDR_W-1:0]     paddr,
  input  logic [lms_pkg::DATA_W-1:0]     pwdata,
  output logic [lms_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import lms_pkg::*;

  cfg_t                 cfg;
  logic                 in_valid_r;
  logic [1:0]           evt_r;
  logic                 fire;
  logic                 in_take;
  logic [LED_COUNT-1:0] pins_nxt;
  stat_t                stat_nxt;
  logic                 out_valid_r;
  logic [LED_COUNT-1:0] pins_r;
  stat_t                stat_r;

  lms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lms_engine #(
    .LED_COUNT (LED_COUNT)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .evt      (evt_r),
    .cfg      (cfg),
    .pins_nxt (pins_nxt),
    .stat_nxt (stat_nxt)
  );

  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      evt_r <= in_button_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pins_r <= pins_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_pins   = pins_r;
  assign out_pwm_enable = stat_r.pwm_enable;
  assign out_pwm_level  = stat_r.pwm_level;
  assign out_mode       = stat_r.mode;
  assign out_dwell_ms   = stat_r.dwell_ms;

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("result register not loaded after update");

  a_pwm_only_breathe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pwm_enable |-> out_mode == MODE_BREATHE)
    else $error("pwm enabled outside breathe mode");

  a_level_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode != MODE_BREATHE |-> out_pwm_level == '0)
    else $error("pwm level nonzero outside breathe mode");

  a_pins_dark_breathe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == MODE_BREATHE |-> out_led_pins == '0)
    else $error("led pins driven in breathe mode");

endmodule

>>> tb/testbench.sv
module testbench;
  import lms_pkg::*;

  typedef struct packed {
    logic [3:0]         pins;
    logic               pwm_en;
    logic [LEVEL_W-1:0] level;
    mode_t              mode;
    logic [DWELL_W-1:0] dwell;
  } led_status_t;

  typedef struct {
    logic [1:0]  evt;
    bit          fixed;
    led_status_t status;
  } stim_row_t;

  localparam int N_DIRECTED  = 23;
  localparam int PHASE_BEATS = 88;

  // next mode, rows by current mode, columns b1 b2 b3 none
  localparam mode_t TRANSITIONS [4][4] = '{
    '{MODE_CHASE_DOWN, MODE_BLINK,      MODE_BREATHE, MODE_CHASE_UP},
    '{MODE_CHASE_UP,   MODE_CHASE_DOWN, MODE_BREATHE, MODE_BLINK},
    '{MODE_BLINK,      MODE_CHASE_UP,   MODE_BREATHE, MODE_CHASE_DOWN},
    '{MODE_CHASE_UP,   MODE_CHASE_UP,   MODE_CHASE_UP, MODE_BREATHE}
  };

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{EVT_NONE, 1'b1, '{4'h1, 1'b0, 13'd0,  MODE_CHASE_UP,   10'd300}},
    '{EVT_NONE, 1'b1, '{4'h2, 1'b0, 13'd0,  MODE_CHASE_UP,   10'd300}},
    '{EVT_B2,   1'b1, '{4'hf, 1'b0, 13'd0,  MODE_BLINK,      10'd300}},
    '{EVT_NONE, 1'b1, '{4'h0, 1'b0, 13'd0,  MODE_BLINK,      10'd300}},
    '{EVT_B2,   1'b1, '{4'h8, 1'b0, 13'd0,  MODE_CHASE_DOWN, 10'd200}},
    '{EVT_NONE, 1'b1, '{4'h4, 1'b0, 13'd0,  MODE_CHASE_DOWN, 10'd200}},
    '{EVT_B3,   1'b1, '{4'h0, 1'b1, 13'd0,  MODE_BREATHE,    10'd10}},
    '{EVT_NONE, 1'b1, '{4'h0, 1'b1, 13'd50, MODE_BREATHE,    10'd10}},
    '{EVT_B1,   1'b1, '{4'h1, 1'b0, 13'd0,  MODE_CHASE_UP,   10'd300}},
    '{EVT_B1,   1'b0, '0},
    '{EVT_B1,   1'b0, '0},
    '{EVT_B1,   1'b0, '0},
    '{EVT_B3,   1'b0, '0},
    '{EVT_NONE, 1'b0, '0},
    '{EVT_B2,   1'b0, '0},
    '{EVT_B2,   1'b0, '0},
    '{EVT_B3,   1'b0, '0},
    '{EVT_B3,   1'b0, '0},
    '{EVT_NONE, 1'b0, '0},
    '{EVT_B1,   1'b0, '0},
    '{EVT_B2,   1'b0, '0},
    '{EVT_B1,   1'b0, '0},
    '{EVT_B3,   1'b0, '0}
  };

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_button_event = EVT_NONE;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          out_led_pins;
  logic                out_pwm_enable;
  logic [LEVEL_W-1:0]  out_pwm_level;
  logic [1:0]          out_mode;
  logic [DWELL_W-1:0]  out_dwell_ms;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // sequencer state as predicted
  mode_t              seq_mode = MODE_CHASE_UP;
  logic [1:0]         seq_idx = 2'd0;
  logic [3:0]         seq_pins = 4'h0;
  logic [LEVEL_W-1:0] ramp_lvl = '0;
  logic               ramp_rising = 1'b0;
  logic               pwm_on_q = 1'b0;
  logic [LEVEL_W-1:0] applied_lvl = '0;

  logic [LEVEL_W-1:0] cfg_top = RST_PWM_TOP;
  logic [STEP_W-1:0]  cfg_step = RST_RAMP_STEP;
  logic [DWELL_W-1:0] cfg_dwell [4] = '{RST_DWELL_CHASE_UP, RST_DWELL_BLINK,
                                         RST_DWELL_CHASE_DOWN, RST_DWELL_BREATHE};

  led_status_t pending_status_q [$];
  int          errors = 0;
  int          burst_left = 0;
  logic [9:0]  stall_tick = '0;

  led_mode_sequencer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_event (in_button_event),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_pins    (out_led_pins),
    .out_pwm_enable  (out_pwm_enable),
    .out_pwm_level   (out_pwm_level),
    .out_mode        (out_mode),
    .out_dwell_ms    (out_dwell_ms),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic led_status_t advance_sequencer(logic [1:0] evt);
    mode_t      nxt;
    logic [1:0] neighbor;
    int         lvl;
    nxt = TRANSITIONS[seq_mode][evt];
    if (nxt != seq_mode) begin
      if (seq_mode == MODE_BREATHE) begin
        applied_lvl = '0;
        pwm_on_q = 1'b0;
      end
      seq_pins = 4'h0;
      seq_idx = (nxt == MODE_CHASE_DOWN) ? 2'd3 : 2'd0;
      if (nxt == MODE_BREATHE) begin
        pwm_on_q = 1'b1;
        ramp_rising = 1'b1;
      end
      seq_mode = nxt;
    end
    case (seq_mode)
      MODE_CHASE_UP: begin
        neighbor = seq_idx - 2'd1;
        seq_pins[neighbor] = 1'b0;
        seq_pins[seq_idx] = 1'b1;
        seq_idx = seq_idx + 2'd1;
      end
      MODE_BLINK: begin
        seq_pins = (seq_pins != 4'h0) ? 4'h0 : 4'hf;
      end
      MODE_CHASE_DOWN: begin
        neighbor = seq_idx + 2'd1;
        seq_pins[neighbor] = 1'b0;
        seq_pins[seq_idx] = 1'b1;
        seq_idx = seq_idx - 2'd1;
      end
      default: begin
        applied_lvl = ramp_lvl;
        if (ramp_rising) begin
          lvl = int'(ramp_lvl) + int'(cfg_step);
          if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
          ramp_lvl = LEVEL_W'(lvl);
          if (ramp_lvl >= cfg_top) ramp_rising = 1'b0;
        end else begin
          ramp_lvl = (ramp_lvl > LEVEL_W'(cfg_step)) ? ramp_lvl - LEVEL_W'(cfg_step) : '0;
          if (ramp_lvl == '0) ramp_rising = 1'b1;
        end
      end
    endcase
    return '{seq_pins, pwm_on_q, applied_lvl, seq_mode, cfg_dwell[seq_mode]};
  endfunction

  task automatic send_beat(input logic [1:0] evt, input bit fixed, input led_status_t status);
    led_status_t predicted;
    in_valid <= 1'b1;
    in_button_event <= evt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_sequencer(evt);
    pending_status_q.push_back(fixed ? status : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] wdata);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PWM_TOP:          cfg_top = wdata[LEVEL_W-1:0];
      REG_RAMP_STEP:        cfg_step = wdata[STEP_W-1:0];
      REG_DWELL_CHASE_UP:   cfg_dwell[MODE_CHASE_UP] = wdata[DWELL_W-1:0];
      REG_DWELL_BLINK:      cfg_dwell[MODE_BLINK] = wdata[DWELL_W-1:0];
      REG_DWELL_CHASE_DOWN: cfg_dwell[MODE_CHASE_DOWN] = wdata[DWELL_W-1:0];
      REG_DWELL_BREATHE:    cfg_dwell[MODE_BREATHE] = wdata[DWELL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_cfg(input int unsigned top, input int unsigned step,
                           input int unsigned d_up, input int unsigned d_blink,
                           input int unsigned d_down, input int unsigned d_breathe);
    drain();
    cfg_write(REG_PWM_TOP, top);
    cfg_write(REG_RAMP_STEP, step);
    cfg_write(REG_DWELL_CHASE_UP, d_up);
    cfg_write(REG_DWELL_BLINK, d_blink);
    cfg_write(REG_DWELL_CHASE_DOWN, d_down);
    cfg_write(REG_DWELL_BREATHE, d_breathe);
  endtask

  // a long breathe stretch first, then event plus idle-period runs
  task automatic run_phase(input int n);
    int sent;
    int hold;
    send_beat(EVT_B3, 1'b0, '0);
    repeat (40) send_beat(EVT_NONE, 1'b0, '0);
    sent = 41;
    while (sent < n) begin
      send_beat(2'($urandom_range(0, 3)), 1'b0, '0);
      hold = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 45) : $urandom_range(0, 4);
      repeat (hold) send_beat(EVT_NONE, 1'b0, '0);
      sent += hold + 1;
      if ($urandom_range(0, 30) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_beat(directed_rows[r].evt, directed_rows[r].fixed, directed_rows[r].status);
    end
    run_phase(PHASE_BEATS);
    apply_cfg(0, 255, 0, 1023, 0, 1023);
    run_phase(PHASE_BEATS);
    apply_cfg(8191, 255, 1023, 0, 1023, 0);
    run_phase(PHASE_BEATS);
    apply_cfg(1, 1, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    run_phase(PHASE_BEATS);
    repeat (2) begin
      apply_cfg($urandom_range(0, 8191), $urandom_range(0, 255), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      run_phase(PHASE_BEATS);
    end
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // receiver back-pressure cycles through free, light, heavy and periodic stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick[1:0] == 2'd0);
    endcase
  end

  always @(posedge clk) begin
    led_status_t got;
    led_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_led_pins, out_pwm_enable, out_pwm_level, mode_t'(out_mode), out_dwell_ms};
      if (pending_status_q.size() == 0) begin
        if (errors < 20) $display("%0t: unexpected result beat pins=%h", $time, got.pins);
        errors++;
      end else begin
        want = pending_status_q.pop_front();
        if (got !== want) begin
          if (errors < 20) begin
            $display("%0t: expected pins=%h en=%b level=%0d mode=%0d dwell=%0d", $time,
                     want.pins, want.pwm_en, want.level, want.mode, want.dwell);
            $display("%0t:      got pins=%h en=%b level=%0d mode=%0d dwell=%0d", $time,
                     got.pins, got.pwm_en, got.level, got.mode, got.dwell);
          end
          errors++;
        end
      end
    end
  end

endmodule
